>>> hw/rtl/cjf_pkg.sv
package cjf_pkg;

    // queue geometry
    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ID_W      = 64;
    localparam int PAYLOAD_W = 32;
    localparam int PAY_W     = 32;
    localparam int TOTAL_W   = 32;

    // stream widths
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 208;
    localparam int M_USER_W = 2;

    // operation codes
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_CANCEL  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // memory port control from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } cjf_mem_ctl_t;

    // logical queue position to physical slot, wrapping at DEPTH
    function automatic logic [ADDR_W-1:0] cjf_slot(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] pos);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> hw/rtl/cjf_store.sv
module cjf_store
    import cjf_pkg::*;
(
    input  logic                 aclk,
    input  cjf_mem_ctl_t         ctl,
    input  logic [ID_W-1:0]      wr_id,
    input  logic [PAYLOAD_W-1:0] wr_pay,
    output logic [ID_W-1:0]      rd_id,
    output logic [PAYLOAD_W-1:0] rd_pay
);

    logic [ID_W-1:0]      id_mem  [DEPTH];
    logic [PAYLOAD_W-1:0] pay_mem [DEPTH];
    logic [ID_W-1:0]      rd_id_reg;
    logic [PAYLOAD_W-1:0] rd_pay_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            id_mem[ctl.waddr]  <= wr_id;
            pay_mem[ctl.waddr] <= wr_pay;
        end
        rd_id_reg  <= id_mem[ctl.raddr];
        rd_pay_reg <= pay_mem[ctl.raddr];
    end

    assign rd_id  = rd_id_reg;
    assign rd_pay = rd_pay_reg;

endmodule

>>> hw/rtl/cancelable_job_fifo.sv
// channel | direction | tdata (low bit up)              | tuser
// s_      | in        | job_id, payload                 | op
// m_      | out       | out_job_id, out_payload, pending, | status
//         |           | totals enq/deq/cancel, peak     |
//
// one word at a time: enqueue steps through start and result, pop adds a
// read step, cancel scans the held entries (one slot read per cycle over the
// single memory read port), then moves one slot per cycle to close the gap
// the result sits in an output register; a stalled m_ side holds the
// sequencer in its last step until the word is taken
// aresetn clears the queue count, head, totals and peak; slots are not cleared
module cancelable_job_fifo
    import cjf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // job_id[63:0], payload[95:64]
    input  logic [S_USER_W-1:0] s_tuser,  // op[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_job_id[63:0], out_payload[95:64], pending[100:96],
    // total_enqueued[132:101], total_dequeued[164:133],
    // total_cancelled[196:165], peak[201:197], zero[207:202]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser   // status[1:0]
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_POPRD  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]     peak_reg, peak_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [TOTAL_W-1:0]   enq_reg, enq_next;
    logic [TOTAL_W-1:0]   deq_reg, deq_next;
    logic [TOTAL_W-1:0]   can_reg, can_next;
    logic [1:0]           op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [1:0]           status_reg, status_next;
    logic [ID_W-1:0]      rid_reg, rid_next;
    logic [PAYLOAD_W-1:0] rpay_reg, rpay_next;
    logic                 mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0]  mdata_reg, mdata_next;
    logic [M_USER_W-1:0]  muser_reg, muser_next;

    cjf_mem_ctl_t         mem_ctl;
    logic [ID_W-1:0]      wr_id;
    logic [PAYLOAD_W-1:0] wr_pay;
    logic [ID_W-1:0]      rd_id;
    logic [PAYLOAD_W-1:0] rd_pay;

    logic [CNT_W-1:0]     idx_ext;
    logic                 scan_last;
    logic                 shift_last;
    logic                 out_free;

    cjf_store u_store (
        .aclk   (aclk),
        .ctl    (mem_ctl),
        .wr_id  (wr_id),
        .wr_pay (wr_pay),
        .rd_id  (rd_id),
        .rd_pay (rd_pay)
    );

    assign idx_ext    = {{(CNT_W - ADDR_W){1'b0}}, idx_reg};
    assign scan_last  = (idx_ext + CNT_W'(1)) == occ_reg;
    assign shift_last = (idx_ext + CNT_W'(2)) == occ_reg;
    assign out_free   = !mvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        peak_next   = peak_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        enq_next    = enq_reg;
        deq_next    = deq_reg;
        can_next    = can_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        pay_next    = pay_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        rpay_next   = rpay_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mem_ctl.we    = 1'b0;
        mem_ctl.waddr = cjf_slot(head_reg, occ_reg[ADDR_W-1:0]);
        mem_ctl.raddr = cjf_slot(head_reg, idx_reg + ADDR_W'(1));
        wr_id  = id_reg;
        wr_pay = pay_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    id_next     = s_tdata[ID_W-1:0];
                    pay_next    = s_tdata[ID_W +: PAYLOAD_W];
                    status_next = ST_OK;
                    rid_next    = '0;
                    rpay_next   = '0;
                    state_next  = S_START;
                end
            end
            S_START: begin
                idx_next   = '0;
                state_next = S_RESULT;
                unique case (op_reg)
                    OP_ENQUEUE: begin
                        if (occ_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_ctl.we = 1'b1;
                            occ_next   = occ_reg + CNT_W'(1);
                            enq_next   = enq_reg + TOTAL_W'(1);
                            if (occ_reg + CNT_W'(1) > peak_reg) begin
                                peak_next = occ_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_POP, OP_CANCEL: begin
                        mem_ctl.raddr = head_reg;
                        if (occ_reg == '0) begin
                            status_next = ST_MISS;
                        end else if (op_reg == OP_POP) begin
                            state_next = S_POPRD;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POPRD: begin
                rid_next   = rd_id;
                rpay_next  = rd_pay;
                head_next  = cjf_slot(head_reg, ADDR_W'(1));
                occ_next   = occ_reg - CNT_W'(1);
                deq_next   = deq_reg + TOTAL_W'(1);
                state_next = S_RESULT;
            end
            S_SCAN: begin
                // read data is slot idx, next slot already being fetched
                if (rd_id == id_reg) begin
                    rid_next  = rd_id;
                    rpay_next = rd_pay;
                    if (scan_last) begin
                        occ_next   = occ_reg - CNT_W'(1);
                        can_next   = can_reg + TOTAL_W'(1);
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else if (scan_last) begin
                    status_next = ST_MISS;
                    state_next  = S_RESULT;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_SHIFT: begin
                // move slot idx+1 down into idx, fetch idx+2
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = cjf_slot(head_reg, idx_reg);
                mem_ctl.raddr = cjf_slot(head_reg, idx_reg + ADDR_W'(2));
                wr_id  = rd_id;
                wr_pay = rd_pay;
                if (shift_last) begin
                    occ_next   = occ_reg - CNT_W'(1);
                    can_next   = can_reg + TOTAL_W'(1);
                    state_next = S_RESULT;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    muser_next  = status_reg;
                    mdata_next  = {6'b0, 5'(peak_reg), can_reg, deq_reg, enq_reg,
                                   5'(occ_reg), PAY_W'(rpay_reg), rid_reg};
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            peak_reg   <= '0;
            head_reg   <= '0;
            enq_reg    <= '0;
            deq_reg    <= '0;
            can_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            peak_reg   <= peak_next;
            head_reg   <= head_next;
            enq_reg    <= enq_next;
            deq_reg    <= deq_next;
            can_reg    <= can_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // working and output words
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        pay_reg    <= pay_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rpay_reg   <= rpay_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

>>> hw/rtl/cjf_checker.sv
module cjf_checker
    import cjf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: taking a word closes the input side
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a full rejection reports a full queue
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[100:96] == 5'(DEPTH))
        else $error("full status with queue not full");

    // peak never below pending
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[201:197] >= m_tdata[100:96])
        else $error("peak below pending");

endmodule

bind cancelable_job_fifo cjf_checker u_cjf_checker (.*);

>>> verif/cancelable_job_fifo_test.sv
`timescale 1ns / 1ps

module cancelable_job_fifo_test;
    import cjf_pkg::*;

    // op code 3 is unused by the block and must act as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int unsigned RANDOM_JOBS = 1750;
    localparam int unsigned HOLD_AFTER_RESULTS = 300;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

    // one expected result word, unpacked into its fields
    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    job_id;
        logic [PAY_W-1:0]   payload;
        logic [CNT_W-1:0]   pending;
        logic [TOTAL_W-1:0] enq_total;
        logic [TOTAL_W-1:0] deq_total;
        logic [TOTAL_W-1:0] cancel_total;
        logic [CNT_W-1:0]   peak;
    } job_result_t;

    // job queue shadow and the results it predicts
    class job_queue_scoreboard;
        logic [ID_W-1:0]    held_ids[$];
        logic [PAY_W-1:0]   held_payloads[$];
        logic [TOTAL_W-1:0] enq_total;
        logic [TOTAL_W-1:0] deq_total;
        logic [TOTAL_W-1:0] cancel_total;
        logic [CNT_W-1:0]   high_water;
        job_result_t        expected_results[$];
        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            enq_total    = '0;
            deq_total    = '0;
            cancel_total = '0;
            high_water   = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // apply one accepted word to the shadow queue
        function void note_job_word(logic [1:0] op, logic [ID_W-1:0] id,
                                    logic [PAY_W-1:0] pay);
            job_result_t r;
            int hit;
            r = '0;
            r.status = ST_OK;
            hit = -1;
            case (op)
                OP_ENQUEUE: begin
                    if (held_ids.size() >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        held_ids.insert(held_ids.size(), id);
                        held_payloads.insert(held_payloads.size(), pay);
                        enq_total++;
                        if (held_ids.size() > int'(high_water)) begin
                            high_water = CNT_W'(held_ids.size());
                        end
                    end
                end
                OP_POP: begin
                    if (held_ids.size() == 0) begin
                        r.status = ST_MISS;
                    end else begin
                        r.job_id  = held_ids[0];
                        r.payload = held_payloads[0];
                        held_ids.delete(0);
                        held_payloads.delete(0);
                        deq_total++;
                    end
                end
                OP_CANCEL: begin
                    // oldest match only
                    for (int i = 0; i < held_ids.size() && hit < 0; i++) begin
                        if (held_ids[i] == id) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ST_MISS;
                    end else begin
                        r.job_id  = held_ids[hit];
                        r.payload = held_payloads[hit];
                        held_ids.delete(hit);
                        held_payloads.delete(hit);
                        cancel_total++;
                    end
                end
                default: begin
                end
            endcase
            r.pending      = CNT_W'(held_ids.size());
            r.enq_total    = enq_total;
            r.deq_total    = deq_total;
            r.cancel_total = cancel_total;
            r.peak         = high_water;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at result %0d, %s: expected %h, got %h",
                             results_seen, label, want, got);
                end
            end
        endfunction

        // compare one output word against the oldest prediction
        function void check_result_word(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
            job_result_t want;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result %0d: data %h status %h",
                             results_seen, data, user);
                end
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            compare_field("status", 64'(want.status), 64'(user[1:0]));
            compare_field("out_job_id", want.job_id, data[63:0]);
            compare_field("out_payload", 64'(want.payload), 64'(data[95:64]));
            compare_field("pending", 64'(want.pending), 64'(data[100:96]));
            compare_field("total_enqueued", 64'(want.enq_total), 64'(data[132:101]));
            compare_field("total_dequeued", 64'(want.deq_total), 64'(data[164:133]));
            compare_field("total_cancelled", 64'(want.cancel_total), 64'(data[196:165]));
            compare_field("peak", 64'(want.peak), 64'(data[201:197]));
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // job_id[63:0], payload[95:64]
    logic [S_USER_W-1:0] s_tuser  = '0;  // op[1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // out_job_id, out_payload, pending, totals enq/deq/cancel, peak, zero fill
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;        // status[1:0]

    job_queue_scoreboard ledger;
    bit                  steady = 1'b0;
    logic [ID_W-1:0]     id_pool[8];

    cancelable_job_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // offer one word, with a random gap before it, and wait for the handshake
    task automatic send_job_word(input logic [1:0] op, input logic [ID_W-1:0] id,
                                 input logic [PAY_W-1:0] pay);
        while (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, id};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        ledger.note_job_word(op, id, pay);
    endtask

    function automatic logic [1:0] pick_op(traffic_mix_t mix);
        int unsigned roll;
        int unsigned enq_pct;
        int unsigned pop_pct;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin enq_pct = 65; pop_pct = 15; end
            MIX_DRAIN: begin enq_pct = 20; pop_pct = 40; end
            default:   begin enq_pct = 40; pop_pct = 28; end
        endcase
        if (roll < 3) return OP_NOP;
        if (roll < 3 + enq_pct) return OP_ENQUEUE;
        if (roll < 3 + enq_pct + pop_pct) return OP_POP;
        return OP_CANCEL;
    endfunction

    // result side: random stalls, one long hold-off to back up the input
    initial begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                ledger.check_result_word(m_tdata, m_tuser);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && ledger != null
                         && ledger.results_seen >= HOLD_AFTER_RESULTS) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 17);
            end
        end
    end

    // job traffic
    initial begin : stimulus
        traffic_mix_t    mix;
        int unsigned     burst_left;
        logic [1:0]      op;
        logic [ID_W-1:0] id;
        int unsigned     drain_wait;
        ledger = new();
        burst_left = 0;
        mix = MIX_EVEN;
        foreach (id_pool[k]) id_pool[k] = {$urandom, $urandom};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue, unused op, field extremes
        send_job_word(OP_POP, 64'h0123_4567_89ab_cdef, 32'h5a5a_5a5a);
        send_job_word(OP_CANCEL, '1, '1);
        send_job_word(OP_NOP, '1, '1);
        send_job_word(OP_ENQUEUE, '0, '0);
        send_job_word(OP_ENQUEUE, '1, '1);
        send_job_word(OP_ENQUEUE, 64'h55, 32'h1111_1111);
        send_job_word(OP_ENQUEUE, 64'h8000_0000_0000_0000, 32'h8000_0000);
        send_job_word(OP_ENQUEUE, 64'h55, 32'h2222_2222);
        // duplicate id: only the older copy goes, from the middle
        send_job_word(OP_CANCEL, 64'h55, '0);
        send_job_word(OP_CANCEL, 64'h77, '0);
        send_job_word(OP_POP, '0, '0);
        // cancel at the tail
        send_job_word(OP_CANCEL, 64'h55, '0);
        // fill up, then overflow
        for (int i = 0; i < 14; i++) begin
            send_job_word(OP_ENQUEUE, 64'ha000 + 64'(i), $urandom);
        end
        send_job_word(OP_ENQUEUE, 64'hdead_beef_0000_0001, 32'hffff_0000);
        send_job_word(OP_CANCEL, 64'ha00d, '0);
        send_job_word(OP_CANCEL, '1, '0);

        // random bursts over a small id pool so cancels hit and ids repeat
        for (int unsigned n = 0; n < RANDOM_JOBS; n++) begin
            if (burst_left == 0) begin
                mix = traffic_mix_t'($urandom_range(2));
                burst_left = $urandom_range(60, 20);
                id_pool[$urandom_range(7)] = {$urandom, $urandom};
                id_pool[$urandom_range(7)] = {$urandom, $urandom};
            end
            burst_left--;
            steady = (n >= 700 && n < 1000);
            op = pick_op(mix);
            if ($urandom_range(99) < ((op == OP_CANCEL) ? 80 : 70)) begin
                id = id_pool[$urandom_range(7)];
            end else begin
                id = {$urandom, $urandom};
            end
            send_job_word(op, id, $urandom);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // let the last results out, then a short quiet tail
        drain_wait = 0;
        while (ledger.expected_results.size() != 0 && drain_wait < 20000) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (40) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/cjf_pkg.sv
hw/rtl/cjf_store.sv
hw/rtl/cancelable_job_fifo.sv
hw/rtl/cjf_checker.sv
verif/cancelable_job_fifo_test.sv
